// ===== rtl/rsvt_pkg.sv =====
`default_nettype none

package rsvt_pkg;

   // operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_NODATA = 2'd2;

   // register indexes
   localparam logic CSR_FIRST_INDEX = 1'b0;
   localparam logic CSR_LAST_INDEX  = 1'b1;

   localparam logic [31:0] FIRST_INDEX_RESET = 32'd0;
   localparam logic [31:0] LAST_INDEX_RESET  = 32'd4095;

   // epoch tags: an entry is valid when its tag equals the live epoch
   localparam int unsigned EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_STALE = 8'h00;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'h01;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_RESOLVE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } store_cmd_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } store_stat_type;

endpackage

`default_nettype wire

// ===== rtl/rsvt_store.sv =====
`default_nettype none

module rsvt_store
   import rsvt_pkg::*;
#(
   parameter int ENTRIES     = 4096,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire store_cmd_type                  cmd,
   input  wire logic [$clog2(ENTRIES)-1:0]     rd_slot,
   input  wire logic [$clog2(ENTRIES)-1:0]     wr_slot,
   input  wire logic [VALUE_WIDTH-1:0]         wr_value,
   output store_stat_type                      stat,
   output logic [VALUE_WIDTH-1:0]              rd_value
);

   localparam int AW = $clog2(ENTRIES);
   localparam int MW = EPOCH_W + VALUE_WIDTH;
   localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);

   logic [MW-1:0]      mem [ENTRIES];
   logic [MW-1:0]      rd_data_ff;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               sweep_ff, sweep_in;
   logic [AW-1:0]      sweep_cnt_ff, sweep_cnt_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [MW-1:0]      mem_wdata;

   // sweep overrides the normal write port; no items run during a sweep
   always_comb begin
      if (sweep_ff) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_cnt_ff;
         mem_wdata = {EPOCH_STALE, {VALUE_WIDTH{1'b0}}};
      end else begin
         mem_we    = cmd.wr_en;
         mem_waddr = wr_slot;
         mem_wdata = {epoch_ff, wr_value};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   always_comb begin
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == LAST_SLOT) begin
            sweep_in     = 1'b0;
            sweep_cnt_in = '0;
         end
      end else if (cmd.clear) begin
         if (epoch_ff == EPOCH_LAST) begin
            // tags would wrap: wipe every tag, restart epochs
            epoch_in     = EPOCH_FIRST;
            sweep_in     = 1'b1;
            sweep_cnt_in = '0;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= EPOCH_FIRST;
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
      end else begin
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   assign stat.busy = sweep_ff;
   assign stat.hit  = (rd_data_ff[MW-1 -: EPOCH_W] == epoch_ff);
   assign rd_value  = rd_data_ff[VALUE_WIDTH-1:0];

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != EPOCH_STALE)
      else $error("live epoch equals stale tag");

   a_no_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !(cmd.rd_en || cmd.wr_en || cmd.clear))
      else $error("access during clearing sweep");

   a_wrap_sweeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.clear && !sweep_ff && epoch_ff == EPOCH_LAST) |=> sweep_ff)
      else $error("epoch wrap without sweep");

endmodule

`default_nettype wire

// ===== rtl/ranged_sparse_value_table_unit.sv =====
`default_nettype none

// channel  | direction | ports                                         | transfer when
// ---------+-----------+-----------------------------------------------+----------------------
// request  | in        | req_operation, req_block_index, req_write_value | req_valid & req_ready
// response | out       | rsp_status, rsp_read_value                    | rsp_valid & rsp_ready
// csr      | in        | csr_index, csr_write_data                     | csr_write_enable
//
// An item goes through accept, window check plus memory read, then resolve
// into the response register; the registered store read sets this order.
// A waiting response does not block acceptance of the next request.
// After reset, and after every 255th clear, a tag-clearing sweep runs over all
// ENTRIES slots with req_ready low. Synchronous active-high reset.
// A stalled response holds the item in resolve until the output register frees.

module ranged_sparse_value_table_unit
   import rsvt_pkg::*;
#(
   parameter int ENTRIES     = 4096,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_block_index,
   input  wire logic [31:0] req_write_value,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_read_value,

   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);

   localparam int AW = $clog2(ENTRIES);

   state_type        state_ff, state_in;

   // captured request
   logic [1:0]       op_ff;
   logic [31:0]      idx_ff;
   logic [31:0]      wval_ff;

   // window registers
   logic [31:0]      first_ff;
   logic [31:0]      last_ff;

   // lookup results
   logic [31:0]      offset;
   logic             in_range;
   logic             in_range_ff;
   logic [AW-1:0]    slot_ff;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_read_value_ff, rsp_read_value_in;

   logic             out_free;
   logic             rsp_load;

   store_cmd_type    cmd;
   store_stat_type   stat;
   logic [VALUE_WIDTH-1:0] rd_value;

   // ---------------------------------------------------------------
   // Window check: index within [first, last] and offset below depth
   // ---------------------------------------------------------------
   assign offset   = idx_ff - first_ff;
   assign in_range = (idx_ff >= first_ff) && (idx_ff <= last_ff) &&
                     (offset < 32'(ENTRIES));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !stat.busy;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      rsp_load          = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            // read only on an in-window read; data lands next cycle
            cmd.rd_en = (op_ff == OP_READ) && in_range;
            state_in  = S_RESOLVE;
         end
         S_RESOLVE: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               cmd.wr_en = (op_ff == OP_WRITE) && in_range_ff;
               cmd.clear = (op_ff == OP_CLEAR);
               state_in  = S_IDLE;
               case (op_ff)
                  OP_READ: begin
                     if (!in_range_ff) begin
                        rsp_status_in     = STATUS_RANGE;
                        rsp_read_value_in = '0;
                     end else if (stat.hit) begin
                        rsp_status_in     = STATUS_OK;
                        rsp_read_value_in = 32'(rd_value);
                     end else begin
                        rsp_status_in     = STATUS_NODATA;
                        rsp_read_value_in = '0;
                     end
                  end
                  OP_WRITE: begin
                     rsp_status_in     = in_range_ff ? STATUS_OK : STATUS_RANGE;
                     rsp_read_value_in = '0;
                  end
                  default: begin
                     // clear, and the unused code, answer ok
                     rsp_status_in     = STATUS_OK;
                     rsp_read_value_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= FIRST_INDEX_RESET;
         last_ff      <= LAST_INDEX_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIRST_INDEX: first_ff <= csr_write_data;
               CSR_LAST_INDEX:  last_ff  <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_operation;
         idx_ff  <= req_block_index;
         wval_ff <= req_write_value;
      end
      if (state_ff == S_LOOKUP) begin
         in_range_ff <= in_range;
         slot_ff     <= offset[AW-1:0];
      end
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   // ---------------------------------------------------------------
   // Value store with epoch tags
   // ---------------------------------------------------------------
   rsvt_store #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_slot  (offset[AW-1:0]),
      .wr_slot  (slot_ff),
      .wr_value (VALUE_WIDTH'(wval_ff)),
      .stat     (stat),
      .rd_value (rd_value)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;

   a_load_from_resolve: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == S_RESOLVE) && out_free)
      else $error("response loaded outside resolve");

   a_error_has_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_read_value_ff == '0))
      else $error("error response carries data");

   a_write_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (op_ff == OP_WRITE) && in_range_ff)
      else $error("store write outside window");

   a_lookup_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_LOOKUP))
      else $error("accepted request not looked up");

endmodule

`default_nettype wire

// ===== dv/value_table_checker.sv =====
`timescale 1ns / 100ps

module value_table_checker
   import rsvt_pkg::*;
#(
   parameter int ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_block_index,
   input  logic [31:0] req_write_value,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_read_value,

   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,

   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
   } answer_type;

   logic [31:0]        win_first = FIRST_INDEX_RESET;
   logic [31:0]        win_last  = LAST_INDEX_RESET;
   logic [ENTRIES-1:0] slot_valid = '0;
   logic [31:0]        slot_value [ENTRIES];
   answer_type         awaited_answers [$];
   int                 errors = 0;

   // one table access: updates the shadow table, returns the answer it gives
   function automatic answer_type access_table(input logic [1:0]  op,
                                               input logic [31:0] idx,
                                               input logic [31:0] wval);
      answer_type  ans;
      logic [31:0] offset;
      logic        hit;
      ans.status     = STATUS_OK;
      ans.read_value = '0;
      offset         = idx - win_first;
      hit = (idx >= win_first) && (idx <= win_last) && (offset < 32'(ENTRIES));
      if (op == OP_READ || op == OP_WRITE) begin
         if (!hit) begin
            ans.status = STATUS_RANGE;
         end else if (op == OP_WRITE) begin
            slot_valid[offset] = 1'b1;
            slot_value[offset] = wval;
         end else if (slot_valid[offset]) begin
            ans.read_value = slot_value[offset];
         end else begin
            ans.status = STATUS_NODATA;
         end
      end else if (op == OP_CLEAR) begin
         slot_valid = '0;   // values stay, valid bits go
      end
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         win_first  = FIRST_INDEX_RESET;
         win_last   = LAST_INDEX_RESET;
         slot_valid = '0;
         awaited_answers.delete();
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               errors++;
               $display("%0t: unexpected response transfer: status %0d read_value %h",
                        $time, rsp_status, rsp_read_value);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value mismatch: expected %h actual %h",
                           $time, want.read_value, rsp_read_value);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_answers.push_back(access_table(req_operation, req_block_index,
                                                   req_write_value));
         if (csr_write_enable) begin
            if (csr_index == CSR_FIRST_INDEX) begin
               win_first = csr_write_data;
            end else begin
               win_last = csr_write_data;
            end
         end
      end
      fail_count    <= errors;
      pending_count <= awaited_answers.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rsvt_pkg::*;

   localparam int ENTRIES    = 4096;
   // the RTL has no name for the spare opcode; it must act as a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // long enough for the tag sweep after reset / 255th clear plus the long hold
   localparam int QUIET_LIMIT = 20000;
   localparam int LONG_HOLD   = 300;

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [31:0] req_block_index;
   logic [31:0] req_write_value;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_value;

   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   int          fail_count;
   int          pending_count;

   // idling knobs, percent of cycles
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          hold_go       = 1'b0;
   int          quiet_cycles  = 0;

   // stimulus-side view of the window and of which slots were ever written,
   // so a read never lands on a store entry that holds no defined value yet
   logic [31:0]        win_lo;
   logic [31:0]        win_hi;
   logic [ENTRIES-1:0] written;
   int unsigned        written_slots [$];

   ranged_sparse_value_table_unit #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (32)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   value_table_checker #(
      .ENTRIES (ENTRIES)
   ) table_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // 10 ns clock, first rising edge at 5 ns
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receive side. A long hold keeps rsp_ready low until the LONG_HOLD wait here
   // ends, so the pipeline backs up into req_ready.
   always @(posedge clock) begin
      if (hold_go) begin
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD) @(posedge clock);
         hold_go = 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offset of idx in the current window; true when it maps to a slot
   function automatic logic window_slot(input logic [31:0] idx, output int unsigned slot);
      logic [31:0] offset;
      offset = idx - win_lo;
      slot   = offset;
      return (idx >= win_lo) && (idx <= win_hi) && (offset < 32'(ENTRIES));
   endfunction

   function automatic logic [1:0] pick_op(input int clear_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < clear_pct)
         return OP_CLEAR;
      if (roll < clear_pct + 2)
         return OP_UNUSED;
      return $urandom_range(1) ? OP_WRITE : OP_READ;
   endfunction

   // Mostly slots already in use or low offsets, plus just past the window edges,
   // the last slot, the first offset past the depth and fully random indexes.
   function automatic logic [31:0] pick_index(input logic [1:0] op);
      logic [31:0] cand;
      int unsigned slot;
      int          k;
      cand = win_lo;
      for (k = 0; k < 8; k++) begin
         case ($urandom_range(15))
            0, 1:    cand = $urandom();
            2:       cand = win_lo - 32'd1;
            3:       cand = win_hi + 32'd1;
            4:       cand = win_lo + 32'(ENTRIES);
            5:       cand = win_lo + 32'(ENTRIES - 1);
            6, 7, 8, 9, 10: begin
               if (written_slots.size() != 0)
                  cand = win_lo + written_slots[$urandom_range(written_slots.size() - 1)];
               else
                  cand = win_lo;
            end
            default: cand = win_lo + $urandom_range(63);
         endcase
         if (op != OP_READ || !window_slot(cand, slot) || written[slot])
            return cand;
      end
      return cand;
   endfunction

   // One request transfer. Valid stays up until accepted; gaps go before it.
   task automatic send_item(input logic [1:0] op, input logic [31:0] idx,
                            input logic [31:0] wval);
      int unsigned slot;
      // a read of a never-written slot turns into the write that fills it
      if (op == OP_READ && window_slot(idx, slot) && !written[slot])
         op = OP_WRITE;
      if (op == OP_WRITE && window_slot(idx, slot) && !written[slot]) begin
         written[slot] = 1'b1;
         written_slots.push_back(slot);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_block_index <= idx;
      req_write_value <= wval;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every outstanding answer
   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);   // three-stage pipe, let it settle
   endtask

   // window registers change only with the block idle
   task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIRST_INDEX;
      csr_write_data   <= lo;
      @(posedge clock);
      csr_index        <= CSR_LAST_INDEX;
      csr_write_data   <= hi;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      win_lo = lo;
      win_hi = hi;
   endtask

   initial begin : stimulus
      logic [31:0] lo;
      logic [1:0]  op;
      int          phase;
      int          n;
      int          count;
      int          clear_pct;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_READ;
      req_block_index  = '0;
      req_write_value  = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FIRST_INDEX;
      csr_write_data   = '0;
      win_lo           = FIRST_INDEX_RESET;
      win_hi           = LAST_INDEX_RESET;
      written          = '0;
      count            = 0;
      clear_pct        = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed, reset window 0..4095 ----
      send_item(OP_WRITE, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_READ, 32'd0, 32'h0);
      send_item(OP_WRITE, 32'd4095, 32'h0000_0000);
      send_item(OP_READ, 32'd4095, 32'hFFFF_FFFF);   // write data ignored on read
      send_item(OP_WRITE, 32'd4096, 32'h5555_5555);  // above the window
      send_item(OP_READ, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_WRITE, 32'd0, 32'h1234_5678);     // overwrite
      send_item(OP_READ, 32'd0, 32'h0);
      send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_READ, 32'd0, 32'h0);              // cleared: no data
      send_item(OP_READ, 32'd4095, 32'h0);
      send_item(OP_UNUSED, 32'd0, 32'hFFFF_FFFF);    // spare opcode is a no-op
      send_item(OP_READ, 32'd0, 32'h0);
      send_item(OP_WRITE, 32'd5, 32'hA5A5_A5A5);

      // window moves by one: old entries show up at shifted indexes
      set_window(32'd1, 32'hFFFF_FFFF);
      send_item(OP_READ, 32'd6, 32'h0);
      send_item(OP_READ, 32'd0, 32'h0);              // below the window
      send_item(OP_WRITE, 32'd4097, 32'h0);          // inside window, past depth
      send_item(OP_READ, 32'd4096, 32'h0);

      // window at the top of the index space
      set_window(32'hFFFF_F000, 32'hFFFF_FFFF);
      send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0001);
      send_item(OP_READ, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_READ, 32'hFFFF_EFFF, 32'h0);

      // first above last: everything out of range
      set_window(32'd100, 32'd99);
      send_item(OP_READ, 32'd100, 32'h0);
      send_item(OP_WRITE, 32'd99, 32'h0);

      // single-entry window
      set_window(32'd5, 32'd5);
      send_item(OP_READ, 32'd5, 32'h0);
      send_item(OP_WRITE, 32'd5, 32'h0000_0077);
      send_item(OP_READ, 32'd5, 32'h0);

      // ---- random phases, each with its own window and idling mix ----
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               set_window(FIRST_INDEX_RESET, LAST_INDEX_RESET);
               count = 120; clear_pct = 8; send_idle_pct = 0;  rsp_stall_pct = 0;
            end
            1: begin
               set_window(32'd0, 32'hFFFF_FFFF);
               count = 100; clear_pct = 8; send_idle_pct = 59; rsp_stall_pct = 0;
            end
            2: begin
               set_window(32'hFFFF_F000, 32'hFFFF_FFFF);
               count = 100; clear_pct = 8; send_idle_pct = 0;  rsp_stall_pct = 59;
            end
            3: begin
               lo = $urandom();
               set_window(lo, lo + $urandom_range(2 * ENTRIES));
               count = 100; clear_pct = 8; send_idle_pct = 12; rsp_stall_pct = 12;
            end
            4: begin
               // clear-heavy run: enough clears to hit the periodic tag sweep
               set_window(32'd7, 32'd7 + 32'(ENTRIES - 1));
               count = 300; clear_pct = 85; send_idle_pct = 0; rsp_stall_pct = 0;
            end
            5: begin
               set_window(32'd1, 32'd0);
               count = 30; clear_pct = 8; send_idle_pct = 12; rsp_stall_pct = 12;
            end
            default: begin
               set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
               count = 30; clear_pct = 8; send_idle_pct = 59; rsp_stall_pct = 59;
            end
         endcase
         for (n = 0; n < count; n++) begin
            // phase 0: back-pressure the output while requests keep coming,
            // later let everything drain with the sender paused
            if (phase == 0 && n == 40)
               hold_go = 1'b1;
            if (phase == 0 && n == 90)
               wait_drained();
            op = pick_op(clear_pct);
            send_item(op, pick_index(op), $urandom());
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
